### hdl/vdtsc_pkg.sv
// Package for the video dot timing and scroll counter.
// Holds the timing limits, address field masks and register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vdtsc_pkg;

    localparam int unsigned DotW  = 9;
    localparam int unsigned LineW = 9;
    localparam int unsigned AddrW = 15;
    localparam int unsigned FineW = 3;
    localparam int unsigned ColW  = 8;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 15;

    localparam logic [DotW-1:0]  LAST_DOT      = 9'd340;
    localparam logic [DotW-1:0]  PIX_LAST_DOT  = 9'd256;
    localparam logic [DotW-1:0]  STEP_Y_DOT    = 9'd257;
    localparam logic [DotW-1:0]  COPY_H_DOT    = 9'd258;
    localparam logic [DotW-1:0]  COPY_V_FIRST  = 9'd281;
    localparam logic [DotW-1:0]  COPY_V_LAST   = 9'd304;
    localparam logic [DotW-1:0]  FLAG_DOT      = 9'd1;

    localparam logic [LineW-1:0] LAST_LINE     = 9'd261;
    localparam logic [LineW-1:0] VISIBLE_LINES = 9'd240;
    localparam logic [LineW-1:0] VBLANK_LINE   = 9'd241;

    localparam logic [AddrW-1:0] HORIZ_BITS    = 15'h041F;
    localparam logic [AddrW-1:0] VERT_BITS     = 15'h7BE0;
    localparam logic [AddrW-1:0] FINE_Y_ONE    = 15'h1000;
    localparam logic [4:0]       COARSE_MAX    = 5'd31;
    localparam logic [4:0]       COARSE_Y_WRAP = 5'd29;
    localparam logic [2:0]       FINE_Y_MAX    = 3'd7;

    localparam logic [CfgIdxW-1:0] CFG_BACKGROUND = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_SPRITE     = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_NMI        = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_FINE_X     = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_TEMPLATE   = 3'd4;

    typedef struct packed {
        logic [DotW-1:0]  dot_index;
        logic [LineW-1:0] line_index;
        logic             pixel_valid;
        logic [ColW-1:0]  pixel_column;
        logic [AddrW-1:0] vram_address;
        logic             vblank_status;
        logic             nmi_request;
        logic             frame_done;
        logic             odd_frame;
    } t_result;

endpackage

`default_nettype wire

### hdl/video_dot_timing_scroll_counter_top.sv
// A result is registered when its request is accepted.
// Throughput: one request per cycle, set by the single output register stage;
// a request is taken whenever the output register is empty or being drained.
// Reset (synchronous, active low) clears position, address, parity, vblank,
// configuration and the output valid.
// Depends on vdtsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module video_dot_timing_scroll_counter_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic                              i_tick,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [vdtsc_pkg::DotW-1:0]             o_dot_index,
    output logic [vdtsc_pkg::LineW-1:0]            o_line_index,
    output logic                                   o_pixel_valid,
    output logic [vdtsc_pkg::ColW-1:0]             o_pixel_column,
    output logic [vdtsc_pkg::AddrW-1:0]            o_vram_address,
    output logic                                   o_vblank_status,
    output logic                                   o_nmi_request,
    output logic                                   o_frame_done,
    output logic                                   o_odd_frame,
    input  wire logic                              i_cfg_we,
    input  wire logic [vdtsc_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  wire logic [vdtsc_pkg::CfgDataW-1:0]    i_cfg_data
);

    logic                              r_bg_en;
    logic                              r_spr_en;
    logic                              r_nmi_en;
    logic [vdtsc_pkg::FineW-1:0]       r_fine_x;
    logic [vdtsc_pkg::AddrW-1:0]       r_template;

    logic [vdtsc_pkg::DotW-1:0]        r_dot;
    logic [vdtsc_pkg::LineW-1:0]       r_line;
    logic [vdtsc_pkg::AddrW-1:0]       r_addr;
    logic                              r_parity;
    logic                              r_vblank;

    logic [vdtsc_pkg::DotW-1:0]        n_dot;
    logic [vdtsc_pkg::LineW-1:0]       n_line;
    logic [vdtsc_pkg::AddrW-1:0]       n_addr;
    logic                              n_parity;
    logic                              n_vblank;

    logic                              r_out_valid;
    vdtsc_pkg::t_result                r_res;
    vdtsc_pkg::t_result                n_res;

    logic                              accept;
    logic                              rend;
    logic                              visible;
    logic                              prerender;
    logic                              in_pixel;
    logic [vdtsc_pkg::DotW-1:0]        dot_m1;
    logic [vdtsc_pkg::ColW-1:0]        col;
    logic [vdtsc_pkg::FineW-1:0]       fine_sum;
    logic [vdtsc_pkg::DotW-1:0]        end_dot;
    logic [vdtsc_pkg::AddrW-1:0]       addr_cx;
    logic [vdtsc_pkg::AddrW-1:0]       addr_y;
    logic [4:0]                        cy;
    logic [4:0]                        cy_next;
    logic                              v_flip;

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg_en    <= 1'b0;
            r_spr_en   <= 1'b0;
            r_nmi_en   <= 1'b0;
            r_fine_x   <= '0;
            r_template <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                vdtsc_pkg::CFG_BACKGROUND: r_bg_en    <= i_cfg_data[0];
                vdtsc_pkg::CFG_SPRITE:     r_spr_en   <= i_cfg_data[0];
                vdtsc_pkg::CFG_NMI:        r_nmi_en   <= i_cfg_data[0];
                vdtsc_pkg::CFG_FINE_X:     r_fine_x   <= i_cfg_data[vdtsc_pkg::FineW-1:0];
                vdtsc_pkg::CFG_TEMPLATE:   r_template <= i_cfg_data[vdtsc_pkg::AddrW-1:0];
                default: ;
            endcase
        end
    end

    assign rend      = r_bg_en && r_spr_en;
    assign visible   = r_line < vdtsc_pkg::VISIBLE_LINES;
    assign prerender = r_line == vdtsc_pkg::LAST_LINE;
    assign in_pixel  = r_dot >= vdtsc_pkg::FLAG_DOT && r_dot <= vdtsc_pkg::PIX_LAST_DOT;
    assign dot_m1    = r_dot - 9'd1;
    assign col       = dot_m1[vdtsc_pkg::ColW-1:0];
    assign fine_sum  = r_fine_x + col[2:0];
    assign end_dot   = (prerender && r_parity && rend) ? vdtsc_pkg::LAST_DOT - 9'd1
                                                       : vdtsc_pkg::LAST_DOT;

    // coarse X step
    always_comb begin
        addr_cx = r_addr + 15'd1;
        if (r_addr[4:0] == vdtsc_pkg::COARSE_MAX) begin
            addr_cx       = r_addr;
            addr_cx[4:0]  = 5'd0;
            addr_cx[10]   = !r_addr[10];
        end
    end

    // fine and coarse Y step
    always_comb begin
        cy      = r_addr[9:5];
        cy_next = cy + 5'd1;
        v_flip  = 1'b0;
        if (cy == vdtsc_pkg::COARSE_Y_WRAP) begin
            cy_next = 5'd0;
            v_flip  = 1'b1;
        end else if (cy == vdtsc_pkg::COARSE_MAX) begin
            cy_next = 5'd0;
        end
        addr_y = r_addr + vdtsc_pkg::FINE_Y_ONE;
        if (r_addr[14:12] == vdtsc_pkg::FINE_Y_MAX) begin
            addr_y        = r_addr;
            addr_y[14:12] = 3'd0;
            addr_y[9:5]   = cy_next;
            addr_y[11]    = r_addr[11] ^ v_flip;
        end
    end

    always_comb begin
        n_dot    = r_dot;
        n_line   = r_line;
        n_addr   = r_addr;
        n_parity = r_parity;
        n_vblank = r_vblank;
        n_res    = '0;
        if (i_tick) begin
            if (visible) begin
                if (in_pixel) begin
                    n_res.pixel_valid  = 1'b1;
                    n_res.pixel_column = col;
                    if (r_bg_en && fine_sum == 3'd7) begin
                        n_addr = addr_cx;
                    end
                end else if (r_dot == vdtsc_pkg::STEP_Y_DOT && r_bg_en) begin
                    n_addr = addr_y;
                end else if (r_dot == vdtsc_pkg::COPY_H_DOT && rend) begin
                    n_addr = (r_addr & ~vdtsc_pkg::HORIZ_BITS)
                           | (r_template & vdtsc_pkg::HORIZ_BITS);
                end
            end else if (prerender) begin
                if (r_dot == vdtsc_pkg::FLAG_DOT) begin
                    n_vblank = 1'b0;
                end else if (r_dot == vdtsc_pkg::COPY_H_DOT && rend) begin
                    n_addr = (r_addr & ~vdtsc_pkg::HORIZ_BITS)
                           | (r_template & vdtsc_pkg::HORIZ_BITS);
                end else if (r_dot >= vdtsc_pkg::COPY_V_FIRST
                             && r_dot <= vdtsc_pkg::COPY_V_LAST && rend) begin
                    n_addr = (r_addr & ~vdtsc_pkg::VERT_BITS)
                           | (r_template & vdtsc_pkg::VERT_BITS);
                end
            end else if (r_line == vdtsc_pkg::VBLANK_LINE && r_dot == vdtsc_pkg::FLAG_DOT) begin
                n_vblank          = 1'b1;
                n_res.nmi_request = r_nmi_en;
            end

            if (r_dot >= end_dot) begin
                n_res.frame_done = r_line == vdtsc_pkg::VISIBLE_LINES;
                n_dot            = '0;
                if (r_line >= vdtsc_pkg::LAST_LINE) begin
                    n_line   = '0;
                    n_parity = !r_parity;
                end else begin
                    n_line = r_line + 9'd1;
                end
            end else begin
                n_dot = r_dot + 9'd1;
            end
        end
        n_res.dot_index     = n_dot;
        n_res.line_index    = n_line;
        n_res.vram_address  = n_addr;
        n_res.vblank_status = n_vblank;
        n_res.odd_frame     = n_parity;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot    <= '0;
            r_line   <= '0;
            r_addr   <= '0;
            r_parity <= 1'b0;
            r_vblank <= 1'b0;
        end else if (accept) begin
            r_dot    <= n_dot;
            r_line   <= n_line;
            r_addr   <= n_addr;
            r_parity <= n_parity;
            r_vblank <= n_vblank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_dot_index     = r_res.dot_index;
    assign o_line_index    = r_res.line_index;
    assign o_pixel_valid   = r_res.pixel_valid;
    assign o_pixel_column  = r_res.pixel_column;
    assign o_vram_address  = r_res.vram_address;
    assign o_vblank_status = r_res.vblank_status;
    assign o_nmi_request   = r_res.nmi_request;
    assign o_frame_done    = r_res.frame_done;
    assign o_odd_frame     = r_res.odd_frame;

`ifndef SYNTH
    a_nmi_with_vblank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_nmi_request |-> o_vblank_status && o_line_index == vdtsc_pkg::VBLANK_LINE)
        else $error("nmi request without vblank at line 241");

    a_pixel_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pixel_valid |-> o_line_index < vdtsc_pkg::VISIBLE_LINES
            && o_dot_index == {1'b0, o_pixel_column} + 9'd2)
        else $error("pixel column does not match dot position");

    a_frame_done_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_done |-> o_dot_index == 9'd0
            && o_line_index == vdtsc_pkg::VBLANK_LINE)
        else $error("frame done away from start of line 241");

    a_position_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dot <= vdtsc_pkg::LAST_DOT && r_line <= vdtsc_pkg::LAST_LINE)
        else $error("dot or line counter out of range");
`endif

endmodule

`default_nettype wire
